@@ rtl/rsp_pkg.sv @@
// Shared types, constants and GF(256) helpers for the Reed-Solomon parity encoder.
package rsp_pkg;

    localparam int          MAX_PARITY_DEF   = 32;
    localparam int          CFG_W            = 6;
    localparam logic [5:0]  PARITY_COUNT_RST = 6'd10;
    localparam logic [8:0]  GF_POLY          = 9'h11d;
    localparam int          PADDR_W          = 3;
    localparam logic [2:0]  ADDR_PARITY_COUNT = 3'd0;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } t_in_item;

    typedef struct packed {
        logic [7:0] parity_byte;
        logic       last_parity;
    } t_out_item;

    // Control shared by every cell of the chain.
    typedef struct packed {
        logic clear;     // zero the parity byte
        logic step;      // fold a message byte into the parity
        logic load;      // copy the updated parity into the output chain
        logic gen_init;  // seed the generator product with 1
        logic gen_step;  // multiply the generator product by (x + root)
        logic shift;     // move the output chain one place toward the head
    } t_cell_ctl;

    typedef enum logic [2:0] {
        S_INIT  = 3'b001,
        S_BUILD = 3'b010,
        S_RUN   = 3'b100
    } t_state;

    // Multiply by alpha = 2 in GF(256).
    function automatic logic [7:0] gf_xtime(input logic [7:0] a);
        logic [8:0] s;
        s = {a, 1'b0};
        if (s[8]) begin
            s = s ^ GF_POLY;
        end
        return s[7:0];
    endfunction

    // Shift-and-add GF(256) multiply, eight narrow steps.
    function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
        logic [7:0] x;
        logic [7:0] acc;
        x   = a;
        acc = 8'd0;
        for (int k = 0; k < 8; k++) begin
            if (b[k]) begin
                acc = acc ^ x;
            end
            x = gf_xtime(x);
        end
        return acc;
    endfunction

endpackage

@@ rtl/rsp_cell.sv @@
// One cell of the encoder chain: a parity byte, a generator coefficient and an output byte.
module rsp_cell (
    input  logic               i_clk,
    input  rsp_pkg::t_cell_ctl i_ctl,
    input  logic [7:0]         i_fb,
    input  logic [7:0]         i_root,
    input  logic               i_seed,
    input  logic [7:0]         i_nb_par,
    input  logic [7:0]         i_nb_gen,
    input  logic [7:0]         i_nb_out,
    output logic [7:0]         o_par,
    output logic [7:0]         o_gen,
    output logic [7:0]         o_out
);

    logic [7:0] r_par, n_par;
    logic [7:0] r_gen, n_gen;
    logic [7:0] r_out, n_out;
    logic [7:0] w_mul_a;
    logic [7:0] w_prod;
    logic [7:0] w_upd;

    // The multiplier serves the generator build and the message fold, never both at once.
    assign w_mul_a = i_ctl.gen_step ? i_root : i_fb;
    assign w_prod  = rsp_pkg::gf_mul(w_mul_a, r_gen);
    assign w_upd   = i_nb_par ^ w_prod;

    always_comb begin
        n_par = r_par;
        if (i_ctl.clear || i_ctl.load) begin
            n_par = 8'd0;
        end else if (i_ctl.step) begin
            n_par = w_upd;
        end
    end

    always_comb begin
        n_gen = r_gen;
        if (i_ctl.gen_init) begin
            n_gen = {7'd0, i_seed};
        end else if (i_ctl.gen_step) begin
            n_gen = w_prod ^ i_nb_gen;
        end
    end

    always_comb begin
        n_out = r_out;
        if (i_ctl.load) begin
            n_out = w_upd;
        end else if (i_ctl.shift) begin
            n_out = i_nb_out;
        end
    end

    always_ff @(posedge i_clk) begin
        r_par <= n_par;
        r_gen <= n_gen;
        r_out <= n_out;
    end

    assign o_par = r_par;
    assign o_gen = r_gen;
    assign o_out = r_out;

endmodule

@@ rtl/reed_solomon_parity_encoder_core.sv @@
// Top level of the GF(256) Reed-Solomon parity encoder: control, register port and cell chain.
//
//  channel   direction  handshake                 payload
//  input     in         i_in_valid / o_in_ready    i_in_data  (data_byte, last_byte)
//  output    out        o_out_valid / i_out_ready  o_out_data (parity_byte, last_parity)
//  config    in         psel, penable, pwrite      paddr, pwdata, prdata, pready
//
// One message byte is taken per cycle while o_in_ready is high; all cells update their parity byte in parallel.
// A last byte copies the parity into an output chain that drains one byte per cycle while i_out_ready is high,
// so the next message streams in while the previous parity is still leaving.
// Reset and each parity_count write rebuild the generator without input transactions: an init
// state, then a build state that adds one (x + alpha^i) factor per cycle, one per parity byte.
// A last byte waits while the output chain still holds bytes of the previous message.
module reed_solomon_parity_encoder_core #(
    parameter int MAX_PARITY = rsp_pkg::MAX_PARITY_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  rsp_pkg::t_in_item            i_in_data,
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output rsp_pkg::t_out_item           o_out_data,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [rsp_pkg::PADDR_W-1:0]  paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready
);

    localparam int CNT_W = $clog2(MAX_PARITY + 1);

    function automatic logic [CNT_W-1:0] eff_count(input logic [rsp_pkg::CFG_W-1:0] v);
        logic [CNT_W-1:0] n;
        if (v == '0) begin
            n = CNT_W'(1);
        end else if (int'(v) > MAX_PARITY) begin
            n = CNT_W'(MAX_PARITY);
        end else begin
            n = CNT_W'(v);
        end
        return n;
    endfunction

    rsp_pkg::t_state             r_state, n_state;
    logic [rsp_pkg::CFG_W-1:0]   r_cfg;
    logic [CNT_W-1:0]            r_count;
    logic [CNT_W-1:0]            r_bcnt, n_bcnt;
    logic [CNT_W-1:0]            r_rem, n_rem;
    logic [7:0]                  r_root, n_root;

    logic                        w_cfg_wr;
    logic                        w_in_acc;
    logic                        w_out_acc;
    logic                        w_out_free;
    logic [7:0]                  w_fb;
    rsp_pkg::t_cell_ctl          w_ctl;

    logic [7:0] w_par [MAX_PARITY+1];
    logic [7:0] w_gen [MAX_PARITY+1];
    logic [7:0] w_out [MAX_PARITY+1];

    // Register port.
    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite && pready
                      && (paddr == rsp_pkg::ADDR_PARITY_COUNT);
    assign prdata   = (paddr == rsp_pkg::ADDR_PARITY_COUNT)
                      ? {{(32 - rsp_pkg::CFG_W){1'b0}}, r_cfg} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg   <= rsp_pkg::PARITY_COUNT_RST;
            r_count <= eff_count(rsp_pkg::PARITY_COUNT_RST);
        end else if (w_cfg_wr) begin
            r_cfg   <= pwdata[rsp_pkg::CFG_W-1:0];
            r_count <= eff_count(pwdata[rsp_pkg::CFG_W-1:0]);
        end
    end

    // Generator build sequencer.
    always_comb begin
        n_state = r_state;
        n_bcnt  = r_bcnt;
        n_root  = r_root;
        unique case (r_state)
            rsp_pkg::S_INIT: begin
                n_state = rsp_pkg::S_BUILD;
                n_bcnt  = '0;
                n_root  = 8'd1;
            end
            rsp_pkg::S_BUILD: begin
                n_bcnt = r_bcnt + CNT_W'(1);
                n_root = rsp_pkg::gf_xtime(r_root);
                if (r_bcnt == r_count - CNT_W'(1)) begin
                    n_state = rsp_pkg::S_RUN;
                end
            end
            rsp_pkg::S_RUN: begin
                n_state = rsp_pkg::S_RUN;
            end
            default: begin
                n_state = rsp_pkg::S_INIT;
            end
        endcase
        if (w_cfg_wr) begin
            n_state = rsp_pkg::S_INIT;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= rsp_pkg::S_INIT;
            r_bcnt  <= '0;
            r_root  <= 8'd1;
        end else begin
            r_state <= n_state;
            r_bcnt  <= n_bcnt;
            r_root  <= n_root;
        end
    end

    // Handshakes. A last byte needs the output chain empty, or emptying this cycle.
    assign w_out_acc  = o_out_valid && i_out_ready;
    assign w_out_free = (r_rem == '0) || ((r_rem == CNT_W'(1)) && w_out_acc);
    assign o_in_ready = (r_state == rsp_pkg::S_RUN) && !w_cfg_wr
                        && (!i_in_data.last_byte || w_out_free);
    assign w_in_acc   = i_in_valid && o_in_ready;

    assign w_fb = i_in_data.data_byte ^ w_par[0];

    always_comb begin
        w_ctl          = '0;
        w_ctl.clear    = (r_state == rsp_pkg::S_INIT) || w_cfg_wr;
        w_ctl.step     = w_in_acc;
        w_ctl.load     = w_in_acc && i_in_data.last_byte;
        w_ctl.gen_init = (r_state == rsp_pkg::S_INIT);
        w_ctl.gen_step = (r_state == rsp_pkg::S_BUILD);
        w_ctl.shift    = w_out_acc;
    end

    always_comb begin
        n_rem = r_rem;
        if (w_ctl.load) begin
            n_rem = r_count;
        end else if (w_out_acc) begin
            n_rem = r_rem - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rem <= '0;
        end else begin
            r_rem <= n_rem;
        end
    end

    assign o_out_valid            = (r_rem != '0);
    assign o_out_data.parity_byte = w_out[0];
    assign o_out_data.last_parity = (r_rem == CNT_W'(1));

    // Cell chain; the place past the end feeds zeros.
    assign w_par[MAX_PARITY] = 8'd0;
    assign w_gen[MAX_PARITY] = 8'd0;
    assign w_out[MAX_PARITY] = 8'd0;

    for (genvar j = 0; j < MAX_PARITY; j++) begin : g_cell
        rsp_cell u_cell (
            .i_clk    (i_clk),
            .i_ctl    (w_ctl),
            .i_fb     (w_fb),
            .i_root   (r_root),
            .i_seed   (CNT_W'(j) == (r_count - CNT_W'(1))),
            .i_nb_par (w_par[j+1]),
            .i_nb_gen (w_gen[j+1]),
            .i_nb_out (w_out[j+1]),
            .o_par    (w_par[j]),
            .o_gen    (w_gen[j]),
            .o_out    (w_out[j])
        );
    end

    // A last byte queues exactly the effective parity count of bytes (configured value clamped to 1..MAX_PARITY).
    a_load_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_acc && i_in_data.last_byte && !w_cfg_wr) |=> (r_rem == r_count))
        else $error("parity output count does not match parity count");

    // Message bytes are only taken once the generator is complete.
    a_ready_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_ready |-> (r_state == rsp_pkg::S_RUN))
        else $error("input taken during generator build");

    // Each delivered parity byte reduces the remaining count by one.
    a_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_out_acc && !w_ctl.load) |=> (r_rem == $past(r_rem) - CNT_W'(1)))
        else $error("output count did not advance");

    // The build sequence moves to S_RUN after its last step (r_bcnt equal to the parity count minus one).
    a_build_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == rsp_pkg::S_BUILD) && !w_cfg_wr && (r_bcnt == r_count - CNT_W'(1)))
        |=> (r_state == rsp_pkg::S_RUN))
        else $error("generator build did not finish on time");

endmodule
